### design/npc_pkg.sv
// Shared types, palette table and weights for the nearest palette color search.
`default_nettype none
package npc_pkg;

	localparam int unsigned PAL_LEN = 16;
	localparam int unsigned IDX_W   = 4;
	localparam int unsigned DIST_W  = 29;

	localparam logic [5:0] W_R = 6'd30;
	localparam logic [5:0] W_G = 6'd59;
	localparam logic [5:0] W_B = 6'd11;

	localparam logic [DIST_W-1:0] DIST_MAX = '1;

	localparam logic [7:0] PAL_R [PAL_LEN] = '{
		8'd0,   8'd29,  8'd126, 8'd0,   8'd171, 8'd95,  8'd194, 8'd255,
		8'd255, 8'd255, 8'd255, 8'd0,   8'd41,  8'd131, 8'd255, 8'd255
	};
	localparam logic [7:0] PAL_G [PAL_LEN] = '{
		8'd0,   8'd43,  8'd37,  8'd135, 8'd82,  8'd87,  8'd195, 8'd241,
		8'd0,   8'd163, 8'd236, 8'd228, 8'd173, 8'd118, 8'd119, 8'd204
	};
	localparam logic [7:0] PAL_B [PAL_LEN] = '{
		8'd0,   8'd83,  8'd83,  8'd81,  8'd54,  8'd79,  8'd199, 8'd232,
		8'd77,  8'd0,   8'd39,  8'd54,  8'd255, 8'd156, 8'd168, 8'd170
	};

	// Request traveling along the cell chain with the best match so far.
	typedef struct packed {
		logic              valid;
		logic [7:0]        red;
		logic [7:0]        green;
		logic [7:0]        blue;
		logic [DIST_W-1:0] best_d;
		logic [IDX_W-1:0]  best_idx;
	} npc_link_t;

endpackage
`default_nettype wire

### design/npc_cell.sv
// One palette entry: weighted distance in three stages, the last of which keeps the nearer entry.
`default_nettype none
module npc_cell (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic [3:0]        entry_idx,
	input  wire npc_pkg::npc_link_t link_in,
	output npc_pkg::npc_link_t     link_out
);
	import npc_pkg::*;

	npc_link_t link_s1, link_s2, link_s3;
	logic [7:0]  pr, pg, pb;
	logic [7:0]  diff_r, diff_g, diff_b;
	logic [12:0] wr_d, wr_s1;
	logic [13:0] wg_d, wg_s1;
	logic [11:0] wb_d, wb_s1;
	logic [25:0] sq_r_s2;
	logic [27:0] sq_g_s2;
	logic [22:0] sq_b_s2;
	logic [DIST_W-1:0] dist_sum;

	always_comb begin
		pr = PAL_R[entry_idx];
		pg = PAL_G[entry_idx];
		pb = PAL_B[entry_idx];
		diff_r = (link_in.red >= pr) ? link_in.red - pr : pr - link_in.red;
		diff_g = (link_in.green >= pg) ? link_in.green - pg : pg - link_in.green;
		diff_b = (link_in.blue >= pb) ? link_in.blue - pb : pb - link_in.blue;
		wr_d = 13'(diff_r) * 13'(W_R);
		wg_d = 14'(diff_g) * 14'(W_G);
		wb_d = 12'(diff_b) * 12'(W_B);
		dist_sum = DIST_W'(sq_r_s2) + DIST_W'(sq_g_s2) + DIST_W'(sq_b_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_s1 <= '0;
			link_s2 <= '0;
			link_s3 <= '0;
			wr_s1   <= '0;
			wg_s1   <= '0;
			wb_s1   <= '0;
			sq_r_s2 <= '0;
			sq_g_s2 <= '0;
			sq_b_s2 <= '0;
		end else if (en) begin
			link_s1.valid    <= link_in.valid;
			link_s1.red      <= link_in.red;
			link_s1.green    <= link_in.green;
			link_s1.blue     <= link_in.blue;
			link_s1.best_d   <= link_in.best_d;
			link_s1.best_idx <= link_in.best_idx;
			wr_s1 <= wr_d;
			wg_s1 <= wg_d;
			wb_s1 <= wb_d;

			link_s2.valid    <= link_s1.valid;
			link_s2.red      <= link_s1.red;
			link_s2.green    <= link_s1.green;
			link_s2.blue     <= link_s1.blue;
			link_s2.best_d   <= link_s1.best_d;
			link_s2.best_idx <= link_s1.best_idx;
			sq_r_s2 <= 26'(wr_s1) * 26'(wr_s1);
			sq_g_s2 <= 28'(wg_s1) * 28'(wg_s1);
			sq_b_s2 <= 23'(wb_s1) * 23'(wb_s1);

			link_s3.valid <= link_s2.valid;
			link_s3.red   <= link_s2.red;
			link_s3.green <= link_s2.green;
			link_s3.blue  <= link_s2.blue;
			// strict less-than keeps the lowest index on ties
			if (dist_sum < link_s2.best_d) begin
				link_s3.best_d   <= dist_sum;
				link_s3.best_idx <= entry_idx;
			end else begin
				link_s3.best_d   <= link_s2.best_d;
				link_s3.best_idx <= link_s2.best_idx;
			end
		end
	end

	assign link_out = link_s3;

endmodule
`default_nettype wire

### design/nearest_palette_color.sv
// Top level: chain of palette cells with an output register and skid stage.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+-------------------
//  pixel   | pix_valid | pix_stall | red, green, blue
//  index   | idx_valid | idx_stall | palette_index
//
// One pixel per clock while pix_stall is low; three stages per cell
// (weight multiply, square, sum and compare) plus the output register.
// Reset clears all valid flags and the chain registers; the output and skid index registers are not reset.
// The chain advances as one unit; a stalled result parks in the skid stage,
// and pix_stall is that stage's registered full flag.
`default_nettype none
module nearest_palette_color #(
	parameter int unsigned PALETTE_SIZE = 16
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       pix_valid,
	output logic            pix_stall,
	input  wire logic [7:0] red,
	input  wire logic [7:0] green,
	input  wire logic [7:0] blue,
	output logic            idx_valid,
	input  wire logic       idx_stall,
	output logic [3:0]      palette_index
);
	import npc_pkg::*;

	npc_link_t chain [PALETTE_SIZE+1];
	logic pipe_en;
	logic produced;
	logic out_take;
	logic out_valid_q, skid_valid_q;
	logic [IDX_W-1:0] out_idx_q, skid_idx_q;

	assign pipe_en  = !skid_valid_q;
	assign produced = chain[PALETTE_SIZE].valid && pipe_en;
	assign out_take = out_valid_q && !idx_stall;

	assign chain[0] = '{
		valid:    pix_valid,
		red:      red,
		green:    green,
		blue:     blue,
		best_d:   DIST_MAX,
		best_idx: '0
	};

	for (genvar i = 0; i < PALETTE_SIZE; i++) begin : g_cell
		npc_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (pipe_en),
			.entry_idx(4'(i)),
			.link_in  (chain[i]),
			.link_out (chain[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (produced) begin
			if (out_valid_q && !out_take) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_take) begin
				out_idx_q <= skid_idx_q;
			end
		end else if (produced) begin
			if (out_valid_q && !out_take) begin
				skid_idx_q <= chain[PALETTE_SIZE].best_idx;
			end else begin
				out_idx_q <= chain[PALETTE_SIZE].best_idx;
			end
		end
	end

	assign pix_stall     = skid_valid_q;
	assign idx_valid     = out_valid_q;
	assign palette_index = out_idx_q;

`ifndef SYNTH
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid stage full while output register empty");

	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_valid_q && !idx_stall) |=> !skid_valid_q && out_valid_q)
		else $error("skid stage did not drain into output register");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_valid |-> (32'(palette_index) < PALETTE_SIZE))
		else $error("palette index beyond searched entries");
`endif

endmodule
`default_nettype wire

### verif/nearest_palette_color_tb.sv
// Self-checking testbench for nearest_palette_color: nearest 16-color palette index per pixel.
`timescale 1ns / 1ps
module nearest_palette_color_tb;

	localparam int PAL_ENTRIES  = 16;
	localparam int RANDOM_ITEMS = 750;
	localparam int LATENCY      = 3 * PAL_ENTRIES + 1;
	localparam int CYCLE_LIMIT  = 100000;

	localparam logic [23:0] PALETTE [PAL_ENTRIES] = '{
		{8'd0,   8'd0,   8'd0},   {8'd29,  8'd43,  8'd83},
		{8'd126, 8'd37,  8'd83},  {8'd0,   8'd135, 8'd81},
		{8'd171, 8'd82,  8'd54},  {8'd95,  8'd87,  8'd79},
		{8'd194, 8'd195, 8'd199}, {8'd255, 8'd241, 8'd232},
		{8'd255, 8'd0,   8'd77},  {8'd255, 8'd163, 8'd0},
		{8'd255, 8'd236, 8'd39},  {8'd0,   8'd228, 8'd54},
		{8'd41,  8'd173, 8'd255}, {8'd131, 8'd118, 8'd156},
		{8'd255, 8'd119, 8'd168}, {8'd255, 8'd204, 8'd170}
	};

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic       known;
		logic [3:0] idx;
	} pixel_row_t;

	// exact palette colors, corners of the RGB cube, and an exact tie between entries 1 and 5
	localparam pixel_row_t DIRECTED [24] = '{
		{8'd0,   8'd0,   8'd0,   1'b1, 4'd0},  {8'd29,  8'd43,  8'd83,  1'b1, 4'd1},
		{8'd126, 8'd37,  8'd83,  1'b1, 4'd2},  {8'd0,   8'd135, 8'd81,  1'b1, 4'd3},
		{8'd171, 8'd82,  8'd54,  1'b1, 4'd4},  {8'd95,  8'd87,  8'd79,  1'b1, 4'd5},
		{8'd194, 8'd195, 8'd199, 1'b1, 4'd6},  {8'd255, 8'd241, 8'd232, 1'b1, 4'd7},
		{8'd255, 8'd0,   8'd77,  1'b1, 4'd8},  {8'd255, 8'd163, 8'd0,   1'b1, 4'd9},
		{8'd255, 8'd236, 8'd39,  1'b1, 4'd10}, {8'd0,   8'd228, 8'd54,  1'b1, 4'd11},
		{8'd41,  8'd173, 8'd255, 1'b1, 4'd12}, {8'd131, 8'd118, 8'd156, 1'b1, 4'd13},
		{8'd255, 8'd119, 8'd168, 1'b1, 4'd14}, {8'd255, 8'd204, 8'd170, 1'b1, 4'd15},
		{8'd255, 8'd255, 8'd255, 1'b0, 4'd0},  {8'd255, 8'd0,   8'd0,   1'b0, 4'd0},
		{8'd0,   8'd255, 8'd0,   1'b0, 4'd0},  {8'd0,   8'd0,   8'd255, 1'b0, 4'd0},
		{8'd0,   8'd255, 8'd255, 1'b0, 4'd0},  {8'd255, 8'd0,   8'd255, 1'b0, 4'd0},
		{8'd255, 8'd255, 8'd0,   1'b0, 4'd0},  {8'd62,  8'd65,  8'd81,  1'b0, 4'd0}
	};

	logic       clk;
	logic       arst_n;
	logic       pix_valid;
	logic       pix_stall;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic       idx_valid;
	logic       idx_stall;
	logic [3:0] palette_index;

	pixel_row_t expected_index_q [$];
	int         errors = 0;
	int         cycles = 0;
	logic       quiet  = 1'b0;

	nearest_palette_color i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.pix_valid     (pix_valid),
		.pix_stall     (pix_stall),
		.red           (red),
		.green         (green),
		.blue          (blue),
		.idx_valid     (idx_valid),
		.idx_stall     (idx_stall),
		.palette_index (palette_index)
	);

	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [3:0] nearest_index(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b);
		int         dr, dg, db, d, best_d;
		logic [3:0] best;
		best   = '0;
		best_d = 32'h7fff_ffff;
		for (int i = 0; i < PAL_ENTRIES; i++) begin
			dr = (int'(r) - int'(PALETTE[i][23:16])) * 30;
			dg = (int'(g) - int'(PALETTE[i][15:8])) * 59;
			db = (int'(b) - int'(PALETTE[i][7:0])) * 11;
			d  = dr * dr + dg * dg + db * db;
			if (d < best_d) begin
				best_d = d;
				best   = 4'(i);
			end
		end
		return best;
	endfunction

	function automatic logic [7:0] clamp8(input int v);
		return (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : 8'(v);
	endfunction

	task automatic report_mismatch(input string msg);
		errors++;
		if (errors <= 100)
			$display("ERROR @%0t: %s", $time, msg);
	endtask

	// entered and left at a falling edge
	task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
			input logic known, input logic [3:0] typed);
		pixel_row_t req;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			pix_valid = 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		pix_valid = 1'b1;
		red       = r;
		green     = g;
		blue      = b;
		@(posedge clk);
		while (pix_stall)
			@(posedge clk);
		req = {r, g, b, known, known ? typed : nearest_index(r, g, b)};
		expected_index_q.push_back(req);
		@(negedge clk);
	endtask

	initial begin
		int         hold;
		hold      = 0;
		idx_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				idx_stall = 1'b1;
				hold--;
			end else begin
				idx_stall = 1'b0;
				if (!quiet && $urandom_range(0, 7) == 0)
					hold = $urandom_range(1, 5);
			end
		end
	end

	always @(posedge clk) begin
		pixel_row_t exp_req;
		if (arst_n && idx_valid && !idx_stall) begin
			if (expected_index_q.size() == 0) begin
				report_mismatch($sformatf("index %0d with no request outstanding",
					palette_index));
			end else begin
				exp_req = expected_index_q.pop_front();
				if (palette_index !== exp_req.idx)
					report_mismatch($sformatf("rgb %0d,%0d,%0d: index %0d, expected %0d",
						exp_req.r, exp_req.g, exp_req.b, palette_index, exp_req.idx));
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		pixel_row_t  row;
		logic [23:0] pa, pc;
		logic [7:0]  r, g, b;
		pix_valid = 1'b0;
		red       = '0;
		green     = '0;
		blue      = '0;
		arst_n    = 1'b0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		foreach (DIRECTED[i]) begin
			row = DIRECTED[i];
			send_pixel(row.r, row.g, row.b, row.known, row.idx);
		end

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			quiet = (n >= 200 && n < 300) || (n >= RANDOM_ITEMS - 100);
			if (n == 400) begin
				pix_valid = 1'b0;
				while (expected_index_q.size() != 0)
					@(negedge clk);
			end
			pa = PALETTE[$urandom_range(0, PAL_ENTRIES - 1)];
			pc = PALETTE[$urandom_range(0, PAL_ENTRIES - 1)];
			case ($urandom_range(0, 2))
				0: begin
					r = 8'($urandom);
					g = 8'($urandom);
					b = 8'($urandom);
				end
				1: begin
					// close to one palette color
					r = clamp8(int'(pa[23:16]) + $urandom_range(0, 24) - 12);
					g = clamp8(int'(pa[15:8]) + $urandom_range(0, 24) - 12);
					b = clamp8(int'(pa[7:0]) + $urandom_range(0, 24) - 12);
				end
				default: begin
					// halfway between two colors, near or exact ties
					r = clamp8((int'(pa[23:16]) + int'(pc[23:16])) / 2 + $urandom_range(0, 1));
					g = clamp8((int'(pa[15:8]) + int'(pc[15:8])) / 2 + $urandom_range(0, 1));
					b = clamp8((int'(pa[7:0]) + int'(pc[7:0])) / 2 + $urandom_range(0, 1));
				end
			endcase
			send_pixel(r, g, b, 1'b0, 4'd0);
		end
		pix_valid = 1'b0;

		while (expected_index_q.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

### filelist.f
design/npc_pkg.sv
design/npc_cell.sv
design/nearest_palette_color.sv
verif/nearest_palette_color_tb.sv
